// File: hw/rtl/s256h_pkg.sv
package s256h_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } s256h_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } s256h_rsp_type;

   // Datapath strobes from the sequencer to the compression core.
   typedef struct packed {
      logic load;
      logic round;
      logic add;
   } s256h_ctl_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// File: hw/rtl/s256h_ram.sv
module s256h_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/s256h_core.sv
module s256h_core (
   input  logic                    clock,
   input  s256h_pkg::s256h_ctl_type ctl,
   input  logic [5:0]              rnd,
   input  logic [31:0]             buf_word,
   input  logic [31:0]             chain_word,
   output logic [31:0]             sum_word
);

   import s256h_pkg::*;

   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] w_cur;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] choose;
   logic [31:0] major;

   always_comb begin
      // First sixteen rounds take message words; later ones expand the window.
      if (rnd[5:4] == 2'b00) begin
         w_cur = buf_word;
      end else begin
         w_cur = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
      end
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + choose + ROUND_K[rnd] + w_cur;
      t2 = big_sigma0(v_ff[0]) + major;

      v_in   = v_ff;
      win_in = win_ff;
      if (ctl.load) begin
         for (int i = 0; i < 7; i++) v_in[i] = v_ff[i+1];
         v_in[7] = chain_word;
      end else if (ctl.round) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
         win_in[15] = w_cur;
      end else if (ctl.add) begin
         for (int i = 0; i < 7; i++) v_in[i] = v_ff[i+1];
         v_in[7] = v_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      win_ff <= win_in;
   end

   assign sum_word = chain_word + v_ff[0];

endmodule

// File: hw/rtl/sha256_byte_stream_hasher.sv
// Channel | Dir | Handshake            | Payload
// req     | in  | req_valid/req_stall  | data_byte, has_byte, end_of_message
// rsp     | out | rsp_valid/rsp_stall  | digest_word, word_index, last_word
//
// The 64th byte of a block starts a compression: the chaining words are loaded
// from their RAM, then 64 rounds run (one per cycle), then the add-back.
// A close adds padding and length writes, one or two compressions,
// then eight digest words, each through the read, load and hold states.
// Reset is synchronous; chaining words read as the initial values through
// per-entry valid flags, so no clearing pass follows reset.
// rsp_stall holds the digest word in its output register and pauses the block.
module sha256_byte_stream_hasher (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  s256h_pkg::s256h_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output s256h_pkg::s256h_rsp_type rsp_data
);

   import s256h_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_PAD   = 4'd1;
   localparam logic [3:0] ST_ZERO  = 4'd2;
   localparam logic [3:0] ST_LENHI = 4'd3;
   localparam logic [3:0] ST_LENLO = 4'd4;
   localparam logic [3:0] ST_CLOAD = 4'd5;
   localparam logic [3:0] ST_ROUND = 4'd6;
   localparam logic [3:0] ST_ADD   = 4'd7;
   localparam logic [3:0] ST_OREAD = 4'd8;
   localparam logic [3:0] ST_OLOAD = 4'd9;
   localparam logic [3:0] ST_OHOLD = 4'd10;

   localparam logic [5:0] LAST_ROUND  = 6'd63;
   localparam logic [5:0] LAST_BYTE   = 6'd63;
   localparam logic [3:0] LAST_STEP   = 4'd8;
   localparam logic [2:0] LAST_WORD   = 3'd7;
   localparam logic [3:0] LEN_HI_ADDR = 4'd14;
   localparam logic [3:0] LEN_LO_ADDR = 4'd15;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [4:0]  addr_ff, addr_in;
   logic [5:0]  fill_ff, fill_in;
   logic [23:0] acc_ff, acc_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] total_ff, total_in;
   logic        two_blk_ff, two_blk_in;
   logic        close_pend_ff, close_pend_in;
   logic        final_ff, final_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [7:0]  chain_vld_ff, chain_vld_in;
   logic        chain_q_vld_ff;
   logic [2:0]  chain_q_addr_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   s256h_rsp_type rsp_ff, rsp_in;

   s256h_ctl_type ctl;
   logic        buf_we;
   logic [3:0]  buf_waddr;
   logic [31:0] buf_wdata;
   logic [3:0]  buf_raddr;
   logic [31:0] buf_rdata;
   logic        chain_we;
   logic [2:0]  chain_waddr;
   logic [2:0]  chain_raddr;
   logic [31:0] chain_rdata;
   logic [31:0] chain_word;
   logic [31:0] sum_word;
   logic [4:0]  zero_limit;
   logic [31:0] pad_word;

   // Block buffer: sixteen big-endian message words.
   s256h_ram #(.WIDTH(32), .DEPTH(16)) u_buf_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   // Chaining words H0..H7.
   s256h_ram #(.WIDTH(32), .DEPTH(8)) u_chain_ram (
      .clock   (clock),
      .wr_en   (chain_we),
      .wr_addr (chain_waddr),
      .wr_data (sum_word),
      .rd_addr (chain_raddr),
      .rd_data (chain_rdata)
   );

   s256h_core u_core (
      .clock      (clock),
      .ctl        (ctl),
      .rnd        (rnd_ff),
      .buf_word   (buf_rdata),
      .chain_word (chain_word),
      .sum_word   (sum_word)
   );

   // An entry never written since the last digest reads as its initial value.
   assign chain_word = chain_q_vld_ff ? chain_rdata : INIT_H[chain_q_addr_ff];

   // Round r fetches the message word for round r+1.
   assign buf_raddr   = (state_ff == ST_ROUND) ? rnd_ff[3:0] + 4'd1 : 4'd0;
   assign chain_raddr = (state_ff == ST_OREAD) ? oidx_ff : cnt_ff[2:0];
   assign chain_waddr = cnt_ff[2:0] - 3'd1;

   // Zeros run up to the length field, or to the block end when the length spills.
   assign zero_limit = two_blk_ff ? 5'd15 : 5'd13;

   // Partial word: held bytes, then the 0x80 marker, then zeros.
   assign pad_word = {acc_ff, 8'h80} << {2'd3 - fill_ff[1:0], 3'b000};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rnd_in        = rnd_ff;
      addr_in       = addr_ff;
      fill_in       = fill_ff;
      acc_in        = acc_ff;
      bits_in       = bits_ff;
      total_in      = total_ff;
      two_blk_in    = two_blk_ff;
      close_pend_in = close_pend_ff;
      final_in      = final_ff;
      oidx_in       = oidx_ff;
      chain_vld_in  = chain_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      ctl           = '0;
      buf_we        = 1'b0;
      buf_waddr     = addr_ff[3:0];
      buf_wdata     = '0;
      chain_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.has_byte) begin
                  acc_in  = {acc_ff[15:0], req_data.data_byte};
                  fill_in = fill_ff + 6'd1;
                  // Fourth byte completes a word: store it.
                  if (fill_ff[1:0] == 2'd3) begin
                     buf_we    = 1'b1;
                     buf_waddr = fill_ff[5:2];
                     buf_wdata = {acc_ff, req_data.data_byte};
                  end
                  if (fill_ff == LAST_BYTE) begin
                     bits_in       = bits_ff + 64'd512;
                     close_pend_in = req_data.end_of_message;
                     cnt_in        = '0;
                     state_in      = ST_CLOAD;
                  end else if (req_data.end_of_message) begin
                     state_in = ST_PAD;
                  end
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            buf_we     = 1'b1;
            buf_waddr  = fill_ff[5:2];
            buf_wdata  = pad_word;
            addr_in    = {1'b0, fill_ff[5:2]} + 5'd1;
            two_blk_in = (fill_ff[5:3] == 3'd7);
            total_in   = bits_ff + {55'd0, fill_ff, 3'b000};
            state_in   = ST_ZERO;
         end
         ST_ZERO: begin
            if (addr_ff <= zero_limit) begin
               buf_we    = 1'b1;
               buf_waddr = addr_ff[3:0];
               addr_in   = addr_ff + 5'd1;
            end else if (two_blk_ff) begin
               cnt_in   = '0;
               state_in = ST_CLOAD;
            end else begin
               state_in = ST_LENHI;
            end
         end
         ST_LENHI: begin
            buf_we    = 1'b1;
            buf_waddr = LEN_HI_ADDR;
            buf_wdata = total_ff[63:32];
            state_in  = ST_LENLO;
         end
         ST_LENLO: begin
            buf_we    = 1'b1;
            buf_waddr = LEN_LO_ADDR;
            buf_wdata = total_ff[31:0];
            final_in  = 1'b1;
            cnt_in    = '0;
            state_in  = ST_CLOAD;
         end
         ST_CLOAD: begin
            ctl.load = (cnt_ff != 4'd0);
            if (cnt_ff == LAST_STEP) begin
               rnd_in   = '0;
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_ROUND: begin
            ctl.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == LAST_ROUND) begin
               cnt_in   = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            // Read word cnt while writing back word cnt-1.
            if (cnt_ff != 4'd0) begin
               ctl.add                   = 1'b1;
               chain_we                  = 1'b1;
               chain_vld_in[chain_waddr] = 1'b1;
            end
            if (cnt_ff == LAST_STEP) begin
               if (final_ff) begin
                  oidx_in  = '0;
                  state_in = ST_OREAD;
               end else if (two_blk_ff) begin
                  two_blk_in = 1'b0;
                  addr_in    = '0;
                  state_in   = ST_ZERO;
               end else if (close_pend_ff) begin
                  close_pend_in = 1'b0;
                  state_in      = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_OREAD: begin
            state_in = ST_OLOAD;
         end
         ST_OLOAD: begin
            rsp_valid_in      = 1'b1;
            rsp_in.digest_word = chain_word;
            rsp_in.word_index  = oidx_ff;
            rsp_in.last_word   = (oidx_ff == LAST_WORD);
            state_in          = ST_OHOLD;
         end
         ST_OHOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (oidx_ff == LAST_WORD) begin
                  // Digest out: return to the initial state for the next message.
                  final_in     = 1'b0;
                  fill_in      = '0;
                  bits_in      = '0;
                  chain_vld_in = '0;
                  state_in     = ST_IDLE;
               end else begin
                  oidx_in  = oidx_ff + 3'd1;
                  state_in = ST_OREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         bits_ff       <= '0;
         two_blk_ff    <= 1'b0;
         close_pend_ff <= 1'b0;
         final_ff      <= 1'b0;
         chain_vld_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         bits_ff       <= bits_in;
         two_blk_ff    <= two_blk_in;
         close_pend_ff <= close_pend_in;
         final_ff      <= final_in;
         chain_vld_ff  <= chain_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff          <= cnt_in;
      rnd_ff          <= rnd_in;
      addr_ff         <= addr_in;
      acc_ff          <= acc_in;
      total_ff        <= total_in;
      oidx_ff         <= oidx_in;
      rsp_ff          <= rsp_in;
      chain_q_vld_ff  <= chain_vld_ff[chain_raddr];
      chain_q_addr_ff <= chain_raddr;
   end

   a_rsp_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OHOLD)
      else $error("digest word presented outside the hold state");

   a_round_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff != LAST_ROUND) |=>
         (state_ff == ST_ROUND && rnd_ff == $past(rnd_ff) + 6'd1))
      else $error("round counter did not advance");

   a_round_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == LAST_ROUND) |=> state_ff == ST_ADD)
      else $error("compression did not end in add-back");

   a_reset_chain: assert property (@(posedge clock)
      reset |=> chain_vld_ff == 8'h00)
      else $error("chaining valid flags not cleared by reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last_word == (rsp_ff.word_index == LAST_WORD)))
      else $error("last flag does not match word index");

endmodule
